/* rtl/core/cnks_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cnks_pkg;

  // Geometry of the key table and of one text vector.
  localparam int unsigned VectorLen    = 24;
  localparam int unsigned TableEntries = 1024;
  localparam int unsigned CodeW        = 8;
  localparam int unsigned RowW         = VectorLen * CodeW;
  localparam int unsigned PosW         = $clog2(VectorLen + 1);
  localparam int unsigned NormW        = $clog2(VectorLen * 255 * 255 + 1);
  localparam int unsigned ProdW        = 2 * CodeW;
  localparam int unsigned SqW          = 2 * NormW;
  localparam int unsigned MulW         = 2 * NormW;
  localparam int unsigned CmpW         = SqW + NormW;
  localparam int unsigned IdxW         = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW         = $clog2(TableEntries + 1);
  localparam int unsigned BestW        = 10;
  localparam int unsigned EntryW       = RowW + NormW;

  // Command codes on the input channel.
  localparam logic CmdKey   = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // Key table write request from the front end.
  typedef struct packed {
    logic              en;
    logic [IdxW-1:0]   addr;
    logic [RowW-1:0]   row;
    logic [NormW-1:0]  norm;
  } cnks_kwr_t;

  // One query waiting for the scan engine.
  typedef struct packed {
    logic [RowW-1:0]   row;
    logic [NormW-1:0]  norm;
    logic [CntW-1:0]   count;
  } cnks_query_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_DONE
  } cnks_back_state_e;

endpackage

`default_nettype wire

/* rtl/core/cnks_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cnks_in_if
  import cnks_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             command;
  logic [CodeW-1:0] char_code;
  logic             text_end;

  modport source (output valid, output command, output char_code, output text_end,
                  input ready);
  modport sink   (input valid, input command, input char_code, input text_end,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/cnks_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cnks_out_if
  import cnks_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [BestW-1:0] key_index;
  logic             no_match;

  modport source (output valid, output key_index, output no_match, input ready);
  modport sink   (input valid, input key_index, input no_match, output ready);
endinterface

`default_nettype wire

/* rtl/core/cnks_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module cnks_front
  import cnks_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  cnks_in_if.sink      in_i,
  input  wire logic    q_full_i,
  output cnks_kwr_t    kwr_o,
  output logic         q_push_o,
  output cnks_query_t  q_data_o
);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [NormW-1:0] norm_q, norm_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [RowW-1:0]  row_n;
  logic [NormW-1:0] norm_n;
  logic [ProdW-1:0] sq_code;
  logic             accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign sq_code    = ProdW'(in_i.char_code) * ProdW'(in_i.char_code);

  // Place the character into the text vector unless the text is already full.
  always_comb begin
    row_n  = row_q;
    norm_n = norm_q;
    if (pos_q < PosW'(VectorLen)) begin
      for (int j = 0; j < VectorLen; j++) begin
        if (pos_q == PosW'(j)) begin
          row_n[j*CodeW +: CodeW] = in_i.char_code;
        end
      end
      norm_n = norm_q + NormW'(sq_code);
    end
  end

  // Text buffer, table fill count and the requests to the table and queue.
  always_comb begin
    pos_d      = pos_q;
    row_d      = row_q;
    norm_d     = norm_q;
    count_d    = count_q;
    kwr_o.en   = 1'b0;
    kwr_o.addr = count_q[IdxW-1:0];
    kwr_o.row  = row_n;
    kwr_o.norm = norm_n;
    q_push_o   = 1'b0;
    q_data_o.row   = row_n;
    q_data_o.norm  = norm_n;
    q_data_o.count = count_q;
    if (accept) begin
      row_d  = row_n;
      norm_d = norm_n;
      if (pos_q < PosW'(VectorLen)) begin
        pos_d = pos_q + PosW'(1);
      end
      if (in_i.text_end) begin
        pos_d  = '0;
        row_d  = '0;
        norm_d = '0;
        if (in_i.command == CmdKey) begin
          if (count_q < CntW'(TableEntries)) begin
            kwr_o.en = 1'b1;
            count_d  = count_q + CntW'(1);
          end
        end else begin
          q_push_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      row_q   <= '0;
      norm_q  <= '0;
      count_q <= '0;
    end else begin
      pos_q   <= pos_d;
      row_q   <= row_d;
      norm_q  <= norm_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cnks_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module cnks_queue
  import cnks_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire cnks_query_t  push_data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              valid_o,
  output cnks_query_t       pop_data_o
);

  cnks_query_t     mem_q [2];
  logic            wr_q, wr_d;
  logic            rd_q, rd_d;
  logic [1:0]      fill_q, fill_d;

  assign full_o     = (fill_q == 2'd2);
  assign valid_o    = (fill_q != 2'd0);
  assign pop_data_o = mem_q[rd_q];

  // Two-entry ring of pending queries.
  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (push_i) begin
      wr_d = !wr_q;
    end
    if (pop_i) begin
      rd_d = !rd_q;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cnks_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module cnks_back
  import cnks_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cnks_kwr_t    kwr_i,
  input  wire logic         q_valid_i,
  input  wire cnks_query_t  q_data_i,
  output logic              q_pop_o,
  cnks_out_if.source        out_o
);

  // Key table: row and squared norm per entry.
  logic [EntryW-1:0] table_mem [TableEntries];

  cnks_back_state_e state_q, state_d;

  logic [RowW-1:0]  qrow_q, qrow_d;
  logic [CntW-1:0]  lim_q, lim_d;
  logic [CntW-1:0]  iss_q, iss_d;
  logic             phase_q, phase_d;
  logic             issue;

  // Pipeline registers.
  logic              r_v_q;
  logic [IdxW-1:0]   r_idx_q;
  logic [EntryW-1:0] r_data_q;
  logic              p_v_q;
  logic [IdxW-1:0]   p_idx_q;
  logic [NormW-1:0]  p_norm_q;
  logic [ProdW-1:0]  p_prod_q [VectorLen];
  logic              d_v_q;
  logic [IdxW-1:0]   d_idx_q;
  logic [NormW-1:0]  d_norm_q;
  logic [NormW-1:0]  d_dot_q;
  logic [NormW-1:0]  dot_sum;
  logic              s_v_q;
  logic [IdxW-1:0]   s_idx_q;
  logic [NormW-1:0]  s_norm_q;
  logic [SqW-1:0]    s_sq_q;
  logic              c_v_q;
  logic [IdxW-1:0]   c_idx_q;
  logic [NormW-1:0]  c_norm_q;
  logic [SqW-1:0]    c_sq_q;
  logic [MulW-1:0]   c_ahi_q, c_alo_q, c_bhi_q, c_blo_q;

  // Running best.
  logic              found_q, found_d;
  logic [IdxW-1:0]   best_idx_q, best_idx_d;
  logic [SqW-1:0]    best_sq_q, best_sq_d;
  logic [NormW-1:0]  best_norm_q, best_norm_d;

  logic [CmpW-1:0]   lhs, rhs;
  logic              start_clr;

  logic              out_valid_q, out_valid_d;
  logic [BestW-1:0]  out_idx_q, out_idx_d;
  logic              out_nm_q, out_nm_d;

  logic              pipe_busy;

  assign pipe_busy = r_v_q || p_v_q || d_v_q || s_v_q || c_v_q;

  // Table write from the front end and registered read for the scan.
  always_ff @(posedge clk_i) begin
    if (kwr_i.en) begin
      table_mem[kwr_i.addr] <= {kwr_i.row, kwr_i.norm};
    end
    if (issue) begin
      r_data_q <= table_mem[iss_q[IdxW-1:0]];
    end
    r_idx_q <= iss_q[IdxW-1:0];
  end

  // Dot product adder tree over the registered element products.
  always_comb begin
    dot_sum = '0;
    for (int j = 0; j < VectorLen; j++) begin
      dot_sum = dot_sum + NormW'(p_prod_q[j]);
    end
  end

  // Payload stages: products, dot, square, cross products.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < VectorLen; j++) begin
      p_prod_q[j] <= ProdW'(qrow_q[j*CodeW +: CodeW]) *
                     ProdW'(r_data_q[NormW + j*CodeW +: CodeW]);
    end
    p_idx_q  <= r_idx_q;
    p_norm_q <= r_data_q[NormW-1:0];
    d_dot_q  <= dot_sum;
    d_idx_q  <= p_idx_q;
    d_norm_q <= p_norm_q;
    s_sq_q   <= SqW'(d_dot_q) * SqW'(d_dot_q);
    s_idx_q  <= d_idx_q;
    s_norm_q <= d_norm_q;
    c_ahi_q  <= MulW'(s_sq_q[SqW-1:NormW]) * MulW'(best_norm_q);
    c_alo_q  <= MulW'(s_sq_q[NormW-1:0]) * MulW'(best_norm_q);
    c_bhi_q  <= MulW'(best_sq_q[SqW-1:NormW]) * MulW'(s_norm_q);
    c_blo_q  <= MulW'(best_sq_q[NormW-1:0]) * MulW'(s_norm_q);
    c_sq_q   <= s_sq_q;
    c_idx_q  <= s_idx_q;
    c_norm_q <= s_norm_q;
  end

  // Stage valids; a key with zero norm drops out after the read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q <= 1'b0;
      p_v_q <= 1'b0;
      d_v_q <= 1'b0;
      s_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      r_v_q <= issue;
      p_v_q <= r_v_q && (r_data_q[NormW-1:0] != '0);
      d_v_q <= p_v_q;
      s_v_q <= d_v_q;
      c_v_q <= s_v_q;
    end
  end

  // Exact cosine test: dot^2 * best_norm against best_dot^2 * norm.
  assign lhs = (CmpW'(c_ahi_q) << NormW) + CmpW'(c_alo_q);
  assign rhs = (CmpW'(c_bhi_q) << NormW) + CmpW'(c_blo_q);

  always_comb begin
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_sq_d   = best_sq_q;
    best_norm_d = best_norm_q;
    if (start_clr) begin
      found_d     = 1'b0;
      best_idx_d  = '0;
      best_sq_d   = '0;
      best_norm_d = '0;
    end else if (c_v_q && (!found_q || (lhs > rhs))) begin
      found_d     = 1'b1;
      best_idx_d  = c_idx_q;
      best_sq_d   = c_sq_q;
      best_norm_d = c_norm_q;
    end
  end

  // Scan sequencer: a key is issued only while phase_q is low, and phase_q toggles
  // during the scan, so the best is settled before the next comparison.
  always_comb begin
    state_d     = state_q;
    qrow_d      = qrow_q;
    lim_d       = lim_q;
    iss_d       = iss_q;
    phase_d     = phase_q;
    issue       = 1'b0;
    q_pop_o     = 1'b0;
    start_clr   = 1'b0;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_nm_d    = out_nm_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          start_clr = 1'b1;
          qrow_d    = q_data_i.row;
          lim_d     = q_data_i.count;
          iss_d     = '0;
          phase_d   = 1'b0;
          if ((q_data_i.norm == '0) || (q_data_i.count == '0)) begin
            state_d = BK_DONE;
          end else begin
            state_d = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if (iss_q == lim_q) begin
          state_d = BK_DRAIN;
        end else begin
          phase_d = !phase_q;
          if (!phase_q) begin
            issue = 1'b1;
            iss_d = iss_q + CntW'(1);
          end
        end
      end
      BK_DRAIN: begin
        if (!pipe_busy) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_idx_d   = found_q ? BestW'(best_idx_q) : '0;
          out_nm_d    = !found_q;
          state_d     = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      iss_q       <= '0;
      phase_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      phase_q     <= phase_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qrow_q      <= qrow_d;
    lim_q       <= lim_d;
    best_idx_q  <= best_idx_d;
    best_sq_q   <= best_sq_d;
    best_norm_q <= best_norm_d;
    out_idx_q   <= out_idx_d;
    out_nm_q    <= out_nm_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.key_index = out_idx_q;
  assign out_o.no_match  = out_nm_q;

endmodule

`default_nettype wire

/* rtl/core/cosine_nearest_key_search.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Payload                          | Request
// in_i    | in  | command, char_code, text_end     | one text character
// out_o   | out | key_index, no_match              | one query answer
//
// A character is taken whenever the input is ready; key ends write the table at once while it has room.
// A query end is queued and scanned over the keys written so far, through a
// read, product, dot, square and cross product pipeline; keys are spaced out
// as set by the loop that updates the running best.
// Reset clears the text buffer, the fill count and all control; the key
// table needs no clearing. Input stalls only when two queries are pending.

module cosine_nearest_key_search
  import cnks_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cnks_in_if.sink   in_i,
  cnks_out_if.source out_o
);

  cnks_kwr_t   kwr;
  cnks_query_t push_data, pop_data;
  logic        q_full, q_push, q_pop, q_valid;

  cnks_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .kwr_o    (kwr),
    .q_push_o (q_push),
    .q_data_o (push_data)
  );

  cnks_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  cnks_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .kwr_i     (kwr),
    .q_valid_i (q_valid),
    .q_data_i  (pop_data),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire
